/* rtl/cpsm_pkg.sv */
// Shared types and constants for the channel peak and SNR meter.
// No dependencies; every other file of the block uses this package.
package cpsm_pkg;

  // Default line capacity and fixed field widths.
  localparam int MAX_BINS_DEF = 8192;
  localparam int LEVEL_W      = 16;
  localparam int SNR_W        = 17;
  localparam int HZ_W         = 27;
  localparam int LEN_CFG_W    = 14;
  localparam int CFG_IDX_W    = 2;
  localparam int QUEUE_DEPTH  = 4;
  // Quotient bits of the offset noise mean.
  localparam int MEAN_QW      = 16;

  // Register reset values.
  localparam logic [HZ_W-1:0]      SPAN_RST   = 27'd2400000;
  localparam logic [HZ_W-1:0]      CENTER_RST = 27'd0;
  localparam logic [HZ_W-1:0]      WIDTH_RST  = 27'd12500;
  localparam logic [LEN_CFG_W-1:0] LEN_RST    = 14'd8192;

  // Most negative level, start value of the peak hold.
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 16'h8000;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPAN   = 2'd0,
    CFG_CENTER = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_LENGTH = 2'd3
  } cfg_reg_e;

  // The four channel edges, in order of frequency.
  typedef enum logic [1:0] {
    EDGE_OUTER_L = 2'd0,
    EDGE_INNER_L = 2'd1,
    EDGE_INNER_R = 2'd2,
    EDGE_OUTER_R = 2'd3
  } edge_sel_e;

  // Edge unit sequencer.
  typedef enum logic [3:0] {
    C_PREP,
    C_BWN,
    C_F2,
    C_MUL,
    C_SUM,
    C_CHK,
    C_DIV,
    C_SORT,
    C_DONE
  } calc_state_e;

  // Back end sequencer.
  typedef enum logic [1:0] {
    B_RUN,
    B_PREP,
    B_DIV,
    B_PUSH
  } back_state_e;

  // Edge unit status seen by the front end.
  typedef struct packed {
    logic ready;
    logic span_ok;
  } calc_status_t;

  // One classified bin on its way from the front end to the back end.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               noise;
    logic               peak;
    logic               last;
    logic               line_ok;
  } bin_entry_t;

endpackage

/* rtl/cpsm_edge_calc.sv */
// Configuration registers and the edge unit: turns the channel frequencies into four
// clamped bin edges with two sequenced multiplies and a bit-serial divider. Uses cpsm_pkg.
module cpsm_edge_calc #(
  parameter int  MAX_BINS = cpsm_pkg::MAX_BINS_DEF,
  localparam int PW       = $clog2(MAX_BINS),
  localparam int LW       = $clog2(MAX_BINS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cpsm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cpsm_pkg::HZ_W-1:0]           cfg_wdata_i,
  output cpsm_pkg::calc_status_t              status_o,
  output logic [3:0][PW-1:0]                  edges_o,
  output logic [LW-1:0]                       line_len_o
);

  localparam int HW  = cpsm_pkg::HZ_W;
  localparam int LCW = cpsm_pkg::LEN_CFG_W;
  localparam int F2W = HW + 3;            // twice a frequency
  localparam int NW  = F2W + LW + 1;      // signed numerator
  localparam int RW  = NW - 1;            // numerator once known nonnegative
  localparam int DW  = HW + 1;            // divisor, twice the span
  localparam int CW  = (LW > LCW) ? LW : LCW;
  localparam int SW  = $clog2(PW);

  logic [HW-1:0]        span_q;
  logic signed [HW-1:0] center_q;
  logic [HW-1:0]        width_q;
  logic [LCW-1:0]       len_q;

  cpsm_pkg::calc_state_e state_q, state_d;
  cpsm_pkg::edge_sel_e   k_q;

  logic [LW-1:0]         n_q;
  logic                  span_ok_q;
  logic [DW-1:0]         d_q;
  logic [HW+LW-1:0]      bwn_q;
  logic signed [F2W-1:0] f2_q;
  logic signed [NW-1:0]  prod_q;
  logic signed [NW-1:0]  num_q;
  logic [RW-1:0]         rem_q;
  logic [RW-1:0]         dsh_q;
  logic [PW-1:0]         quo_q;
  logic [SW-1:0]         step_q;
  logic [3:0][PW-1:0]    edges_q;

  logic signed [F2W-1:0] c2, w1, w2, f2_sel;
  logic [CW-1:0]         len_ext;
  logic [LW-1:0]         n_clamp;
  logic [LW-1:0]         nm1;
  logic [RW-1:0]         num_lo;
  logic [RW-1:0]         lim;
  logic [RW-1:0]         dsh_init;
  logic [RW:0]           sub;
  logic                  take;
  logic [PW-1:0]         quo_next;
  logic                  last_step;
  logic                  last_edge;
  logic                  edge_wr;
  logic [PW-1:0]         edge_val;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q   <= cpsm_pkg::SPAN_RST;
      center_q <= cpsm_pkg::CENTER_RST;
      width_q  <= cpsm_pkg::WIDTH_RST;
      len_q    <= cpsm_pkg::LEN_RST;
    end else if (cfg_we_i) begin
      case (cpsm_pkg::cfg_reg_e'(cfg_index_i))
        cpsm_pkg::CFG_SPAN:   span_q   <= cfg_wdata_i;
        cpsm_pkg::CFG_CENTER: center_q <= cfg_wdata_i;
        cpsm_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i;
        cpsm_pkg::CFG_LENGTH: len_q    <= cfg_wdata_i[LCW-1:0];
        default: ;
      endcase
    end
  end

  // Twice the edge frequency: 2*center minus or plus width or 2*width.
  always_comb begin
    c2 = {{(F2W-HW-1){center_q[HW-1]}}, center_q, 1'b0};
    w1 = {{(F2W-HW){1'b0}}, width_q};
    w2 = {{(F2W-HW-1){1'b0}}, width_q, 1'b0};
    case (k_q)
      cpsm_pkg::EDGE_OUTER_L: f2_sel = c2 - w2;
      cpsm_pkg::EDGE_INNER_L: f2_sel = c2 - w1;
      cpsm_pkg::EDGE_INNER_R: f2_sel = c2 + w1;
      cpsm_pkg::EDGE_OUTER_R: f2_sel = c2 + w2;
      default:                f2_sel = c2;
    endcase
  end

  // Line length clamped to [2, MAX_BINS].
  always_comb begin
    len_ext = CW'(len_q);
    if (len_ext < CW'(2)) begin
      n_clamp = LW'(2);
    end else if (len_ext > CW'(MAX_BINS)) begin
      n_clamp = LW'(MAX_BINS);
    end else begin
      n_clamp = LW'(len_ext);
    end
  end

  // Divider step and range checks.
  assign nm1       = n_q - LW'(1);
  assign num_lo    = num_q[RW-1:0];
  assign lim       = RW'({bwn_q, 1'b0});
  assign dsh_init  = RW'({d_q, {(PW-1){1'b0}}});
  assign sub       = {1'b0, rem_q} - {1'b0, dsh_q};
  assign take      = !sub[RW];
  assign quo_next  = {quo_q[PW-2:0], take};
  assign last_step = (step_q == SW'(PW - 1));
  assign last_edge = (k_q == cpsm_pkg::EDGE_OUTER_R);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpsm_pkg::C_PREP: state_d = (span_q != '0) ? cpsm_pkg::C_BWN : cpsm_pkg::C_DONE;
      cpsm_pkg::C_BWN:  state_d = cpsm_pkg::C_F2;
      cpsm_pkg::C_F2:   state_d = cpsm_pkg::C_MUL;
      cpsm_pkg::C_MUL:  state_d = cpsm_pkg::C_SUM;
      cpsm_pkg::C_SUM:  state_d = cpsm_pkg::C_CHK;
      cpsm_pkg::C_CHK: begin
        if (!num_q[NW-1] && (num_lo < lim)) begin
          state_d = cpsm_pkg::C_DIV;
        end else begin
          state_d = last_edge ? cpsm_pkg::C_SORT : cpsm_pkg::C_F2;
        end
      end
      cpsm_pkg::C_DIV: begin
        if (last_step) begin
          state_d = last_edge ? cpsm_pkg::C_SORT : cpsm_pkg::C_F2;
        end
      end
      cpsm_pkg::C_SORT: state_d = cpsm_pkg::C_DONE;
      cpsm_pkg::C_DONE: state_d = cpsm_pkg::C_DONE;
      default:          state_d = cpsm_pkg::C_PREP;
    endcase
    // Any register write starts the computation over.
    if (cfg_we_i) begin
      state_d = cpsm_pkg::C_PREP;
    end
  end

  // Outputs and edge write decode.
  always_comb begin
    status_o.ready   = (state_q == cpsm_pkg::C_DONE);
    status_o.span_ok = span_ok_q;
    edge_wr          = 1'b0;
    edge_val         = '0;
    case (state_q)
      cpsm_pkg::C_CHK: begin
        if (num_q[NW-1]) begin
          edge_wr  = 1'b1;
          edge_val = '0;
        end else if (num_lo >= lim) begin
          edge_wr  = 1'b1;
          edge_val = PW'(nm1);
        end
      end
      cpsm_pkg::C_DIV: begin
        if (last_step) begin
          edge_wr  = 1'b1;
          edge_val = quo_next;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpsm_pkg::C_PREP;
      k_q     <= cpsm_pkg::EDGE_OUTER_L;
    end else begin
      state_q <= state_d;
      if (state_q == cpsm_pkg::C_PREP) begin
        k_q <= cpsm_pkg::EDGE_OUTER_L;
      end else if (edge_wr) begin
        k_q <= cpsm_pkg::edge_sel_e'(k_q + 2'd1);
      end
    end
  end

  // Datapath: one multiply per cycle, then a restoring divide one bit a cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      cpsm_pkg::C_PREP: begin
        n_q       <= n_clamp;
        span_ok_q <= (span_q != '0);
        d_q       <= {span_q, 1'b0};
        edges_q   <= '0;
      end
      cpsm_pkg::C_BWN: bwn_q  <= span_q * n_q;
      cpsm_pkg::C_F2:  f2_q   <= f2_sel;
      cpsm_pkg::C_MUL: prod_q <= f2_q * $signed({1'b0, n_q});
      cpsm_pkg::C_SUM: begin
        num_q <= prod_q + $signed({1'b0, bwn_q}) + $signed({1'b0, span_q});
      end
      cpsm_pkg::C_CHK: begin
        rem_q  <= num_lo;
        dsh_q  <= dsh_init;
        quo_q  <= '0;
        step_q <= '0;
        if (edge_wr) begin
          edges_q[k_q] <= edge_val;
        end
      end
      cpsm_pkg::C_DIV: begin
        if (take) begin
          rem_q <= sub[RW-1:0];
        end
        dsh_q  <= dsh_q >> 1;
        quo_q  <= quo_next;
        step_q <= step_q + SW'(1);
        if (edge_wr) begin
          edges_q[k_q] <= edge_val;
        end
      end
      cpsm_pkg::C_SORT: begin
        if (edges_q[0] > edges_q[1]) begin
          edges_q[0] <= edges_q[1];
          edges_q[1] <= edges_q[0];
        end
        if (edges_q[2] > edges_q[3]) begin
          edges_q[2] <= edges_q[3];
          edges_q[3] <= edges_q[2];
        end
      end
      default: ;
    endcase
  end

  assign edges_o    = edges_q;
  assign line_len_o = n_q;

`ifndef SYNTH
  // Finished edges are ordered whenever the span is nonzero.
  a_edges_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cpsm_pkg::C_DONE) && span_ok_q |->
      (edges_q[0] <= edges_q[1]) && (edges_q[1] <= edges_q[2]) &&
      (edges_q[2] <= edges_q[3]))
    else $error("edge unit finished with unordered edges");
`endif

endmodule

/* rtl/cpsm_front.sv */
// Front end: takes bin beats, latches the edges at the start of a line and tags
// each bin as noise, in-channel or neither, plus end of line. Uses cpsm_pkg.
module cpsm_front #(
  parameter int  MAX_BINS = cpsm_pkg::MAX_BINS_DEF,
  localparam int PW       = $clog2(MAX_BINS),
  localparam int LW       = $clog2(MAX_BINS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cpsm_pkg::LEVEL_W-1:0]        bin_level_i,
  input  logic                                cfg_we_i,
  input  cpsm_pkg::calc_status_t              calc_i,
  input  logic [3:0][PW-1:0]                  edges_i,
  input  logic [LW-1:0]                       line_len_i,
  input  logic                                full_i,
  output logic                                push_o,
  output cpsm_pkg::bin_entry_t                entry_o
);

  logic [PW-1:0]      pos_q, pos_d;
  logic               armed_q, armed_d;
  logic [3:0][PW-1:0] edges_q;
  logic [LW-1:0]      n_q;
  logic               ok_q;

  logic               accept;
  logic               arm;
  logic [LW-1:0]      pos_inc;
  logic               last;

  // Bins are taken only once this line's edges are latched.
  assign in_ready_o = armed_q && !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign arm        = !armed_q && calc_i.ready && !cfg_we_i;
  assign pos_inc    = LW'(pos_q) + LW'(1);
  assign last       = (pos_inc >= n_q);

  // Classify the current bin against the latched edges.
  always_comb begin
    entry_o.level   = bin_level_i;
    entry_o.noise   = ((pos_q >= edges_q[0]) && (pos_q < edges_q[1])) ||
                      ((pos_q > edges_q[2]) && (pos_q < edges_q[3]));
    entry_o.peak    = (pos_q >= edges_q[1]) && (pos_q <= edges_q[2]);
    entry_o.last    = last;
    entry_o.line_ok = ok_q;
    push_o          = accept;
  end

  // Bin position and line arming.
  always_comb begin
    pos_d   = pos_q;
    armed_d = armed_q;
    if (accept) begin
      if (last) begin
        pos_d   = '0;
        armed_d = 1'b0;
      end else begin
        pos_d = pos_q + PW'(1);
      end
    end else if (cfg_we_i && (pos_q == '0)) begin
      // A write between lines must reach the next line.
      armed_d = 1'b0;
    end else if (arm) begin
      armed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      armed_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      armed_q <= armed_d;
    end
  end

  // Edge and length snapshot for the line about to start.
  always_ff @(posedge clk_i) begin
    if (arm) begin
      edges_q <= edges_i;
      n_q     <= line_len_i;
      ok_q    <= calc_i.span_ok && (edges_i[1] <= edges_i[2]);
    end
  end

endmodule

/* rtl/cpsm_queue.sv */
// Short queue of classified bins between the front and back ends.
// Uses cpsm_pkg for the entry type and depth.
module cpsm_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cpsm_pkg::bin_entry_t entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output cpsm_pkg::bin_entry_t entry_o,
  output logic                 empty_o
);

  localparam int DEPTH = cpsm_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNW   = $clog2(DEPTH + 1);

  cpsm_pkg::bin_entry_t slot_q [DEPTH];
  logic [AW-1:0]        wr_q;
  logic [AW-1:0]        rd_q;
  logic [CNW-1:0]       cnt_q;

  assign full_o  = (cnt_q == CNW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("bin queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("bin queue read while empty");
`endif

endmodule

/* rtl/cpsm_back.sv */
// Back end: sums the noise bins, holds the channel peak and, at end of line, divides
// out the rounded noise mean one bit a cycle into the result register. Uses cpsm_pkg.
module cpsm_back #(
  parameter int  MAX_BINS = cpsm_pkg::MAX_BINS_DEF,
  localparam int PW       = $clog2(MAX_BINS),
  localparam int LW       = $clog2(MAX_BINS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                empty_i,
  input  cpsm_pkg::bin_entry_t                entry_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cpsm_pkg::LEVEL_W-1:0] peak_level_o,
  output logic signed [cpsm_pkg::SNR_W-1:0]   snr_level_o,
  output logic                                valid_res_o
);

  localparam int LVW  = cpsm_pkg::LEVEL_W;
  localparam int SNW  = cpsm_pkg::SNR_W;
  localparam int QW   = cpsm_pkg::MEAN_QW;
  localparam int QSW  = $clog2(QW);
  localparam int SUMW = LVW + PW;
  localparam int AW   = LW + 17;          // offset numerator 2*sum + cnt + cnt*2^16

  cpsm_pkg::back_state_e state_q, state_d;

  logic signed [SUMW-1:0] sum_q;
  logic [LW-1:0]          cnt_q;
  logic signed [LVW-1:0]  peak_q;
  logic                   ok_q;
  logic [AW-1:0]          rem_q;
  logic [AW-1:0]          dsh_q;
  logic [QW-1:0]          quo_q;
  logic [QSW-1:0]         step_q;
  logic                   out_valid_q;

  logic signed [LVW-1:0]  lvl;
  logic signed [SUMW-1:0] sum_nx;
  logic [LW-1:0]          cnt_nx;
  logic signed [LVW-1:0]  peak_nx;
  logic signed [AW:0]     a_s;
  logic [AW:0]            sub;
  logic                   take;
  logic                   last_step;
  logic                   out_free;
  logic                   load_out;
  logic signed [LVW-1:0]  mean;

  // Accumulator updates for the bin at the queue head.
  assign lvl     = $signed(entry_i.level);
  assign sum_nx  = entry_i.noise ? sum_q + {{(SUMW-LVW){lvl[LVW-1]}}, lvl} : sum_q;
  assign cnt_nx  = entry_i.noise ? cnt_q + LW'(1) : cnt_q;
  assign peak_nx = (entry_i.peak && (lvl > peak_q)) ? lvl : peak_q;

  // Mean offset by 32768 so the dividend is never negative.
  assign a_s = $signed({sum_q, 1'b0}) + $signed({1'b0, cnt_q}) +
               $signed({1'b0, cnt_q, 16'b0});

  assign sub       = {1'b0, rem_q} - {1'b0, dsh_q};
  assign take      = !sub[AW];
  assign last_step = (step_q == QSW'(QW - 1));
  assign out_free  = !out_valid_q || out_ready_i;
  assign mean      = $signed({~quo_q[QW-1], quo_q[QW-2:0]});

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpsm_pkg::B_RUN: begin
        if (!empty_i && entry_i.last) begin
          state_d = (entry_i.line_ok && (cnt_nx != '0)) ? cpsm_pkg::B_PREP
                                                          : cpsm_pkg::B_PUSH;
        end
      end
      cpsm_pkg::B_PREP: state_d = cpsm_pkg::B_DIV;
      cpsm_pkg::B_DIV:  state_d = last_step ? cpsm_pkg::B_PUSH : cpsm_pkg::B_DIV;
      cpsm_pkg::B_PUSH: state_d = out_free ? cpsm_pkg::B_RUN : cpsm_pkg::B_PUSH;
      default:          state_d = cpsm_pkg::B_RUN;
    endcase
  end

  // Queue pop and result load.
  always_comb begin
    pop_o    = (state_q == cpsm_pkg::B_RUN) && !empty_i;
    load_out = (state_q == cpsm_pkg::B_PUSH) && out_free;
  end

  // Control state and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpsm_pkg::B_RUN;
      sum_q       <= '0;
      cnt_q       <= '0;
      peak_q      <= cpsm_pkg::LEVEL_MIN;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        sum_q  <= sum_nx;
        cnt_q  <= cnt_nx;
        peak_q <= peak_nx;
        if (entry_i.last) begin
          ok_q <= entry_i.line_ok && (cnt_nx != '0);
        end
      end else if (load_out) begin
        sum_q  <= '0;
        cnt_q  <= '0;
        peak_q <= cpsm_pkg::LEVEL_MIN;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Restoring divide of the offset numerator by twice the noise bin count.
  always_ff @(posedge clk_i) begin
    case (state_q)
      cpsm_pkg::B_PREP: begin
        rem_q  <= a_s[AW-1:0];
        dsh_q  <= AW'({cnt_q, 16'b0});
        quo_q  <= '0;
        step_q <= '0;
      end
      cpsm_pkg::B_DIV: begin
        if (take) begin
          rem_q <= sub[AW-1:0];
        end
        dsh_q  <= dsh_q >> 1;
        quo_q  <= {quo_q[QW-2:0], take};
        step_q <= step_q + QSW'(1);
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (ok_q) begin
        peak_level_o <= peak_q;
        snr_level_o  <= $signed({peak_q[LVW-1], peak_q}) - $signed({mean[LVW-1], mean});
        valid_res_o  <= 1'b1;
      end else begin
        peak_level_o <= '0;
        snr_level_o  <= '0;
        valid_res_o  <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // A line without a measurement reports zeros.
  a_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> (peak_level_o == '0) && (snr_level_o == '0))
    else $error("invalid result carries nonzero levels");
`endif

endmodule

/* rtl/channel_peak_snr_meter.sv */
// Top level of the channel peak and SNR meter: edge unit, front end, bin queue
// and back end. Depends on cpsm_pkg and the cpsm_* modules.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    bin_level_i
//   out      output     out_valid_o / out_ready_i  peak_level_o, snr_level_o, valid_res_o
//   cfg      input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// Within a line one bin beat is taken per cycle while the queue has room; the first bin
// of a line waits while the edges are latched. After reset or any register write the
// next line may start only once the edge unit has finished. After a valid line with side
// bins the back end runs the 16-step mean divide and then the result load, otherwise
// only the result load; the four-entry queue takes the next line's first bins meanwhile,
// then input stalls.
// No clearing pass follows reset. A stalled output holds the result register and,
// once the queue fills, the input.
module channel_peak_snr_meter #(
  parameter int  MAX_BINS = cpsm_pkg::MAX_BINS_DEF,
  localparam int PW       = $clog2(MAX_BINS),
  localparam int LW       = $clog2(MAX_BINS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [cpsm_pkg::LEVEL_W-1:0] bin_level_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cpsm_pkg::LEVEL_W-1:0] peak_level_o,
  output logic signed [cpsm_pkg::SNR_W-1:0]   snr_level_o,
  output logic                                valid_res_o,
  input  logic                                cfg_we_i,
  input  logic [cpsm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cpsm_pkg::HZ_W-1:0]           cfg_wdata_i
);

  cpsm_pkg::calc_status_t calc_status;
  logic [3:0][PW-1:0]     edges;
  logic [LW-1:0]          line_len;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  cpsm_pkg::bin_entry_t   q_in;
  cpsm_pkg::bin_entry_t   q_out;

  // Registers and edge computation.
  cpsm_edge_calc #(
    .MAX_BINS (MAX_BINS)
  ) u_edge_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (calc_status),
    .edges_o     (edges),
    .line_len_o  (line_len)
  );

  // Bin intake and classification.
  cpsm_front #(
    .MAX_BINS (MAX_BINS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .bin_level_i (bin_level_i),
    .cfg_we_i    (cfg_we_i),
    .calc_i      (calc_status),
    .edges_i     (edges),
    .line_len_i  (line_len),
    .full_i      (q_full),
    .push_o      (q_push),
    .entry_o     (q_in)
  );

  // Decoupling queue.
  cpsm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .empty_o (q_empty)
  );

  // Accumulation, mean divide and result register.
  cpsm_back #(
    .MAX_BINS (MAX_BINS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .entry_i      (q_out),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .peak_level_o (peak_level_o),
    .snr_level_o  (snr_level_o),
    .valid_res_o  (valid_res_o)
  );

endmodule
